// File: rtl/directory_entry_table_defines.svh
// Assertion macros for the directory entry table RTL.
// No dependencies; included by directory_entry_table, the module that carries checks.
`ifndef DIRECTORY_ENTRY_TABLE_DEFINES_SVH
`define DIRECTORY_ENTRY_TABLE_DEFINES_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is high
`define DET_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
// Clocked check that also holds through reset
`define DET_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define DET_ASSERT(lbl, clk, rst, prop)
`define DET_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/det_pkg.sv
// Types and codes for the directory entry table.
// Used by det_cell and directory_entry_table; no dependencies.
package det_pkg;

   localparam int NAME_W = 64;
   localparam int INUM_W = 16;

   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_LIST   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EXISTS    = 2'd2,
      ST_NO_SPACE  = 2'd3
   } status_type;

   // Per-cell command, one set for each cell of the chain
   typedef struct packed {
      logic cmp;      // register the key compare
      logic load;     // take the incoming entry
      logic take_up;  // take the neighbour above (delete closes the gap)
      logic take_dn;  // take the neighbour below (list rotation)
   } cell_ctl_type;

endpackage

// File: rtl/det_cell.sv
// One entry cell of the directory table chain: name, inode number, match flag.
// Depends on det_pkg.
module det_cell (
   input  logic                      clock,
   input  det_pkg::cell_ctl_type     ctl,
   input  logic                      occ,
   input  logic [det_pkg::NAME_W-1:0] key,
   input  logic [det_pkg::INUM_W-1:0] new_inum,
   input  logic [det_pkg::NAME_W-1:0] up_name,
   input  logic [det_pkg::INUM_W-1:0] up_inum,
   input  logic [det_pkg::NAME_W-1:0] dn_name,
   input  logic [det_pkg::INUM_W-1:0] dn_inum,
   output logic [det_pkg::NAME_W-1:0] name,
   output logic [det_pkg::INUM_W-1:0] inum,
   output logic                      match
);
   import det_pkg::*;

   logic [NAME_W-1:0] name_ff, name_in;
   logic [INUM_W-1:0] inum_ff, inum_in;
   logic              match_ff, match_in;

   always_comb begin
      name_in  = name_ff;
      inum_in  = inum_ff;
      match_in = match_ff;
      if (ctl.load) begin
         name_in = key;
         inum_in = new_inum;
      end else if (ctl.take_up) begin
         name_in = up_name;
         inum_in = up_inum;
      end else if (ctl.take_dn) begin
         name_in = dn_name;
         inum_in = dn_inum;
      end
      if (ctl.cmp) begin
         match_in = occ && (name_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      name_ff  <= name_in;
      inum_ff  <= inum_in;
      match_ff <= match_in;
   end

   assign name  = name_ff;
   assign inum  = inum_ff;
   assign match = match_ff;

endmodule

// File: rtl/directory_entry_table.sv
// Directory entry table top level: control sequencer and a chain of entry cells.
// Depends on det_pkg, det_cell and directory_entry_table_defines.svh.
//
// Usage:
//   req_* carries one command (lookup, insert, delete, list) per transfer,
//   rsp_* returns results; rsp_last marks the final result of a command.
//   A transfer happens when valid is high and stall is low.
//   Lookup, insert and delete: one result; the request is registered, the cells
//   register the compare, then the execute state loads the result register. A
//   new request can be taken in the cycle that loads the previous result.
//   List: one result per cycle unless rsp_stall holds it, newest entry first,
//   after the execute state; the cell chain rotates once per result and is
//   back in its original order after the last one. An empty table gives one
//   result with status not-found. Requests are stalled while a list is running.
//   The compare is one registered equality test in every cell; the decision
//   cycle ORs the cell match flags.
//   Reset empties the table (count to zero) and drops any pending result;
//   cell contents are not cleared. A stall on rsp_stall holds the result
//   register and, once full, holds S_EXEC and S_LIST and keeps req_stall high.
`include "directory_entry_table_defines.svh"

module directory_entry_table #(
   parameter int MAX_ENTRIES = 64,
   parameter int NAME_BYTES  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_mode,
   input  logic [det_pkg::NAME_W-1:0] req_key_name,
   input  logic [det_pkg::INUM_W-1:0] req_entry_inum,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [det_pkg::INUM_W-1:0] rsp_found_inum,
   output logic [det_pkg::NAME_W-1:0] rsp_listed_name,
   output logic                      rsp_last
);
   import det_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [NAME_W-1:0] KEY_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC, S_LIST} state_type;

   state_type         st_ff, st_in;
   mode_type          mode_ff, mode_in;
   logic [NAME_W-1:0] key_ff, key_in;
   logic [INUM_W-1:0] inum_ff, inum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [INUM_W-1:0] rsp_inum_ff, rsp_inum_in;
   logic [NAME_W-1:0] rsp_name_ff, rsp_name_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [NAME_W-1:0] cell_name [MAX_ENTRIES];
   logic [INUM_W-1:0] cell_inum [MAX_ENTRIES];
   cell_ctl_type      cell_ctl  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] match_vec, occ_vec, top_vec, free_vec, gap_vec;

   logic              out_free, req_fire, exec_fire, list_fire, hit;
   logic              do_insert, do_delete;
   logic [INUM_W-1:0] hit_inum, tap_inum;
   logic [NAME_W-1:0] tap_name;

   // Occupancy decode and one-hot markers from the live count
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         occ_vec[i]  = CNT_W'(i) < count_ff;
         top_vec[i]  = CNT_W'(i + 1) == count_ff;
         free_vec[i] = CNT_W'(i) == count_ff;
      end
   end

   // Matched entry and top-of-table read, both one-hot AND-OR selects
   always_comb begin
      hit_inum = '0;
      tap_inum = '0;
      tap_name = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_inum = hit_inum | ({INUM_W{match_vec[i]}} & cell_inum[i]);
         tap_inum = tap_inum | ({INUM_W{top_vec[i]}} & cell_inum[i]);
         tap_name = tap_name | ({NAME_W{top_vec[i]}} & cell_name[i]);
      end
   end

   // Cells at or above the deleted entry close the gap (log-step prefix OR)
   always_comb begin
      gap_vec = match_vec;
      for (int s = 1; s < MAX_ENTRIES; s = s * 2) begin
         gap_vec = gap_vec | (gap_vec << s);
      end
   end

   assign hit       = |match_vec;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec_fire = (st_ff == S_EXEC) && out_free;
   assign list_fire = (st_ff == S_LIST) && out_free;
   assign req_stall = !((st_ff == S_IDLE) ||
                        ((st_ff == S_EXEC) && out_free && (mode_ff != MODE_LIST)));
   assign req_fire  = req_valid && !req_stall;
   assign do_insert = exec_fire && (mode_ff == MODE_INSERT) && !hit && (count_ff != CNT_MAX);
   assign do_delete = exec_fire && (mode_ff == MODE_DELETE) && hit;

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         cell_ctl[i].cmp     = st_ff == S_CMP;
         cell_ctl[i].load    = do_insert && free_vec[i];
         cell_ctl[i].take_up = do_delete && gap_vec[i];
         cell_ctl[i].take_dn = list_fire && occ_vec[i];
      end
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [NAME_W-1:0] up_name, dn_name;
      logic [INUM_W-1:0] up_inum, dn_inum;

      if (g == MAX_ENTRIES - 1) begin : g_top
         assign up_name = '0;
         assign up_inum = '0;
      end else begin : g_mid
         assign up_name = cell_name[g + 1];
         assign up_inum = cell_inum[g + 1];
      end

      // Bottom cell takes the top entry, closing the rotation ring
      if (g == 0) begin : g_bot
         assign dn_name = tap_name;
         assign dn_inum = tap_inum;
      end else begin : g_low
         assign dn_name = cell_name[g - 1];
         assign dn_inum = cell_inum[g - 1];
      end

      det_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[g]),
         .occ      (occ_vec[g]),
         .key      (key_ff),
         .new_inum (inum_ff),
         .up_name  (up_name),
         .up_inum  (up_inum),
         .dn_name  (dn_name),
         .dn_inum  (dn_inum),
         .name     (cell_name[g]),
         .inum     (cell_inum[g]),
         .match    (match_vec[g])
      );
   end

   always_comb begin
      st_in         = st_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      inum_in       = inum_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_inum_in   = rsp_inum_ff;
      rsp_name_in   = rsp_name_ff;
      rsp_last_in   = rsp_last_ff;

      case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               st_in = S_CMP;
            end
         end
         S_CMP: begin
            st_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_fire) begin
               rsp_inum_in = '0;
               rsp_name_in = '0;
               rsp_last_in = 1'b1;
               st_in       = req_fire ? S_CMP : S_IDLE;
               case (mode_ff)
                  MODE_LOOKUP: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = hit ? ST_OK : ST_NOT_FOUND;
                     rsp_inum_in   = hit ? hit_inum : '0;
                  end
                  MODE_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (hit) begin
                        rsp_status_in = ST_EXISTS;
                     end else if (count_ff == CNT_MAX) begin
                        rsp_status_in = ST_NO_SPACE;
                     end else begin
                        rsp_status_in = ST_OK;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  MODE_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (hit) begin
                        rsp_status_in = ST_OK;
                        rsp_inum_in   = hit_inum;
                        count_in      = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        rem_in = count_ff;
                        st_in  = S_LIST;
                     end
                  end
               endcase
            end
         end
         S_LIST: begin
            if (list_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_inum_in   = tap_inum;
               rsp_name_in   = tap_name;
               rsp_last_in   = rem_ff == CNT_W'(1);
               rem_in        = rem_ff - 1'b1;
               if (rem_ff == CNT_W'(1)) begin
                  st_in = S_IDLE;
               end
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase

      if (req_fire) begin
         mode_in = mode_type'(req_mode);
         key_in  = req_key_name & KEY_MASK;
         inum_in = req_entry_inum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      inum_ff       <= inum_in;
      rem_ff        <= rem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_inum_ff   <= rsp_inum_in;
      rsp_name_ff   <= rsp_name_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_inum  = rsp_inum_ff;
   assign rsp_listed_name = rsp_name_ff;
   assign rsp_last        = rsp_last_ff;

   `DET_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_MAX)
   `DET_ASSERT(a_no_req_in_list, clock, reset, (st_ff == S_LIST) |-> req_stall)
   `DET_ASSERT(a_insert_grows, clock, reset,
      do_insert |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
   `DET_ASSERT(a_list_ends, clock, reset,
      (list_fire && (rem_ff == CNT_W'(1))) |=> (st_ff == S_IDLE) && rsp_last_ff)
   `DET_ASSERT(a_notfound_last, clock, reset,
      (rsp_valid_ff && (rsp_status_ff == ST_NOT_FOUND)) |-> rsp_last_ff)
   `DET_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (count_ff == '0))

endmodule

// File: tb/directory_entry_table_check.sv
// Checker for the directory entry table: watches both channels, keeps its own copy of
// the table, predicts every result and compares each rsp transfer in order.
// Depends on det_pkg; instantiated beside the block by directory_entry_table_test.
module directory_entry_table_check #(
   parameter int MAX_ENTRIES = 64,
   parameter int NAME_BYTES  = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_mode,
   input  logic [det_pkg::NAME_W-1:0] req_key_name,
   input  logic [det_pkg::INUM_W-1:0] req_entry_inum,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [1:0]                 rsp_status,
   input  logic [det_pkg::INUM_W-1:0] rsp_found_inum,
   input  logic [det_pkg::NAME_W-1:0] rsp_listed_name,
   input  logic                       rsp_last,
   output int                         error_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import det_pkg::*;

   // only the low NAME_BYTES bytes of a name take part
   localparam logic [NAME_W-1:0] KEY_MASK = (NAME_BYTES >= 8) ? '1 :
      ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

   typedef struct packed {
      status_type        status;
      logic [INUM_W-1:0] inum;
      logic [NAME_W-1:0] name;
      logic              last;
   } dir_reply_type;

   logic [NAME_W-1:0] entry_names [MAX_ENTRIES];
   logic [INUM_W-1:0] entry_inums [MAX_ENTRIES];
   int                entry_total = 0;
   dir_reply_type     replies_due [$];
   int                mismatches = 0;

   function automatic void queue_reply(status_type status, logic [INUM_W-1:0] inum,
                                       logic [NAME_W-1:0] name, logic last);
      dir_reply_type r;
      r.status = status;
      r.inum   = inum;
      r.name   = name;
      r.last   = last;
      replies_due.push_back(r);
   endfunction

   function automatic int find_entry(logic [NAME_W-1:0] key);
      for (int i = 0; i < entry_total; i++) begin
         if (entry_names[i] == key) return i;
      end
      return -1;
   endfunction

   // Updates the table copy and queues the results one command produces
   function automatic void apply_command(mode_type mode, logic [NAME_W-1:0] key_in,
                                         logic [INUM_W-1:0] inum);
      logic [NAME_W-1:0] key;
      int                pos;
      key = key_in & KEY_MASK;
      pos = find_entry(key);
      case (mode)
         MODE_LOOKUP: begin
            if (pos < 0) queue_reply(ST_NOT_FOUND, '0, '0, 1'b1);
            else queue_reply(ST_OK, entry_inums[pos], '0, 1'b1);
         end
         MODE_INSERT: begin
            // duplicate wins over full
            if (pos >= 0) begin
               queue_reply(ST_EXISTS, '0, '0, 1'b1);
            end else if (entry_total >= MAX_ENTRIES) begin
               queue_reply(ST_NO_SPACE, '0, '0, 1'b1);
            end else begin
               entry_names[entry_total] = key;
               entry_inums[entry_total] = inum;
               entry_total++;
               queue_reply(ST_OK, '0, '0, 1'b1);
            end
         end
         MODE_DELETE: begin
            if (pos < 0) begin
               queue_reply(ST_NOT_FOUND, '0, '0, 1'b1);
            end else begin
               queue_reply(ST_OK, entry_inums[pos], '0, 1'b1);
               for (int i = pos; i + 1 < entry_total; i++) begin
                  entry_names[i] = entry_names[i + 1];
                  entry_inums[i] = entry_inums[i + 1];
               end
               entry_total--;
            end
         end
         default: begin
            if (entry_total == 0) begin
               queue_reply(ST_NOT_FOUND, '0, '0, 1'b1);
            end else begin
               // newest first
               for (int i = entry_total - 1; i >= 0; i--) begin
                  queue_reply(ST_OK, entry_inums[i], entry_names[i], i == 0);
               end
            end
         end
      endcase
   endfunction

   function automatic void check_reply(dir_reply_type want);
      if (rsp_status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, rsp_status);
         mismatches++;
      end
      if (rsp_found_inum !== want.inum) begin
         $error("found_inum: expected %h, got %h", want.inum, rsp_found_inum);
         mismatches++;
      end
      if (rsp_listed_name !== want.name) begin
         $error("listed_name: expected %h, got %h", want.name, rsp_listed_name);
         mismatches++;
      end
      if (rsp_last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, rsp_last);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      dir_reply_type want;
      if (reset) begin
         entry_total = 0;
         replies_due.delete();
      end else begin
         if (req_valid && !req_stall)
            apply_command(mode_type'(req_mode), req_key_name, req_entry_inum);
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("result transfer with none expected: status %0d, found_inum %h",
                      rsp_status, rsp_found_inum);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               check_reply(want);
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= replies_due.size();
   end

endmodule

// File: tb/directory_entry_table_test.sv
// Top of the directory entry table testbench: clock, reset, command stimulus with
// bursts and gaps, result-side stall pattern, watchdog and verdict.
// Depends on det_pkg, directory_entry_table and directory_entry_table_check.
module directory_entry_table_test;
   timeunit 1ns;
   timeprecision 1ps;
   import det_pkg::*;

   localparam int MAX_ENTRIES    = 64;
   localparam int NAME_BYTES     = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int FILL_KEYS      = 70;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_mode;
   logic [NAME_W-1:0] req_key_name;
   logic [INUM_W-1:0] req_entry_inum;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_status;
   logic [INUM_W-1:0] rsp_found_inum;
   logic [NAME_W-1:0] rsp_listed_name;
   logic              rsp_last;
   int                error_count;
   int                pending_count;

   logic [NAME_W-1:0] key_pool [16];
   int                burst_left = 0;

   directory_entry_table #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .NAME_BYTES (NAME_BYTES)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_key_name   (req_key_name),
      .req_entry_inum (req_entry_inum),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found_inum (rsp_found_inum),
      .rsp_listed_name(rsp_listed_name),
      .rsp_last       (rsp_last)
   );

   directory_entry_table_check #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .NAME_BYTES (NAME_BYTES)
   ) i_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_key_name   (req_key_name),
      .req_entry_inum (req_entry_inum),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found_inum (rsp_found_inum),
      .rsp_listed_name(rsp_listed_name),
      .rsp_last       (rsp_last),
      .error_count    (error_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side stalls with a random density that is redrawn after each random-length span
   initial begin
      int density;
      int span;
      rsp_stall <= 1'b0;
      forever begin
         case ($urandom_range(0, 4))
            0, 1:    density = 0;
            2:       density = 20;
            3:       density = 50;
            default: density = 80;
         endcase
         span = $urandom_range(8, 80);
         repeat (span) begin
            @(posedge clock);
            rsp_stall <= ($urandom_range(1, 100) <= density);
         end
      end
   end

   // Ends the run when nothing has been transferred for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // Called just after a rising edge; returns just after the edge that takes the transfer
   task automatic send_command(mode_type mode, logic [NAME_W-1:0] key,
                               logic [INUM_W-1:0] inum);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_key_name   <= key;
      req_entry_inum <= inum;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sender holds off until every result due has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [NAME_W-1:0] pick_key();
      if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 15)];
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_command();
      int        roll;
      mode_type  mode;
      roll = $urandom_range(0, 99);
      if (roll < 35)      mode = MODE_INSERT;
      else if (roll < 60) mode = MODE_LOOKUP;
      else if (roll < 85) mode = MODE_DELETE;
      else                mode = MODE_LIST;
      send_command(mode, pick_key(), INUM_W'($urandom_range(0, 65535)));
   endtask

   // Fills the table past capacity, lists it full, then empties much of it again
   task automatic fill_table();
      logic [NAME_W-1:0] fresh [FILL_KEYS];
      for (int i = 0; i < FILL_KEYS; i++) begin
         fresh[i] = {$urandom(), $urandom()};
         send_command(MODE_INSERT, fresh[i], INUM_W'($urandom_range(0, 65535)));
      end
      send_command(MODE_INSERT, fresh[3], 16'h0bad);
      send_command(MODE_LOOKUP, fresh[$urandom_range(0, 40)], '0);
      send_command(MODE_LIST, '0, '0);
      for (int i = 0; i < 40; i++)
         send_command(MODE_DELETE, fresh[$urandom_range(0, FILL_KEYS - 1)], '0);
      send_command(MODE_LIST, '0, '0);
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= MODE_LOOKUP;
      req_key_name   <= '0;
      req_entry_inum <= '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 64'h8000_0000_0000_0000;
      for (int i = 3; i < 16; i++) key_pool[i] = {$urandom(), $urandom()};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table, then the zero name, extremes, duplicates and shifting deletes
      send_command(MODE_LIST,   '0, '0);
      send_command(MODE_LOOKUP, key_pool[0], '0);
      send_command(MODE_DELETE, key_pool[1], '0);
      send_command(MODE_INSERT, key_pool[0], 16'h1234);
      send_command(MODE_INSERT, key_pool[1], 16'hffff);
      send_command(MODE_INSERT, key_pool[2], 16'h0000);
      send_command(MODE_INSERT, key_pool[0], 16'h5555);
      send_command(MODE_LOOKUP, key_pool[0], '1);
      send_command(MODE_LOOKUP, key_pool[1], '0);
      send_command(MODE_LOOKUP, key_pool[3], '0);
      send_command(MODE_LIST,   '1, '1);
      send_command(MODE_DELETE, key_pool[1], '0);
      send_command(MODE_LOOKUP, key_pool[2], '0);
      send_command(MODE_LIST,   '0, '0);
      send_command(MODE_DELETE, key_pool[0], '0);
      send_command(MODE_DELETE, key_pool[0], '0);
      send_command(MODE_INSERT, key_pool[3], 16'ha5a5);
      send_command(MODE_LIST,   '0, '0);
      send_command(MODE_DELETE, key_pool[2], '0);
      send_command(MODE_DELETE, key_pool[3], '0);
      send_command(MODE_LIST,   '0, '0);
      drain_results();

      repeat (90) random_command();
      fill_table();
      drain_results();
      repeat (90) random_command();

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
